>>> design/srt_pkg.sv
package srt_pkg;

	localparam logic [3:0] SENDER_NIBBLE = 4'hf;
	localparam int         MAX_SEGMENTS  = 8;
	localparam int         SENDERS       = 4;

	typedef struct packed {
		logic [31:0] id;
		logic        valid;
	} srt_key_t;

	typedef struct packed {
		logic hit;
		logic free;
	} srt_match_t;

endpackage

>>> design/srt_cell.sv
// One tracker: compares the row's shared request key, reports hit/free,
// and carries the hit-so-far / free-so-far chain to its neighbor.
module srt_cell
	import srt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] key_id,
	input  logic        hit_in,
	input  logic        free_in,
	output logic        hit_out,
	output logic        free_out,
	output srt_match_t  match,
	input  logic        alloc,
	input  logic        rel,
	input  logic [31:0] alloc_id
);

	logic [31:0] id_q;
	logic        valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (alloc) begin
			valid_q <= 1'b1;
		end else if (rel) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc) begin
			id_q <= alloc_id;
		end
	end

	assign match.hit  = valid_q && (id_q == key_id) && !hit_in;
	assign match.free = !valid_q && !free_in;
	assign hit_out    = hit_in || (valid_q && (id_q == key_id));
	assign free_out   = free_in || !valid_q;

endmodule

>>> design/segment_reassembly_tracker.sv
// A request is taken at start while idle, its tracker row lookup is registered,
// and the decide state registers its result with strobe; a completed message
// instead reads each stored segment from the registered segment store and then
// emits it, one result per segment (up to MAX_SEGMENTS); others emit one result.
// A new request is taken only once busy falls, as the last result is registered.
// Reset clears the tracker valid bits and sets sender_shift to 24; the receiver
// cannot stall, each result is shown with strobe for one cycle.
module segment_reassembly_tracker
	import srt_pkg::*;
#(
	parameter int TRACKERS     = 16,
	parameter int HANDLE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cfg_we,
	input  logic [4:0]             cfg_wdata,
	input  logic                   is_data,
	input  logic                   ack_req,
	input  logic [31:0]            message_id,
	input  logic [3:0]             segment_count,
	input  logic [2:0]             segment_offset,
	input  logic [HANDLE_BITS-1:0] buffer_handle,
	input  logic                   sink_ready,
	output logic                   strobe,
	output logic                   accepted,
	output logic                   delivering,
	output logic [HANDLE_BITS-1:0] out_buffer,
	output logic [2:0]             out_segment,
	output logic                   last,
	output logic                   ack_push,
	output logic [1:0]             ack_sender,
	output logic [31:0]            ack_message_id,
	output logic                   no_tracker,
	output logic                   bad_sender
);

	localparam int TW = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
	localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int AW = TW + SW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_DEC  = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;

	logic [2:0] state_q;
	logic [4:0] shift_q;

	logic                   data_q, ack_q, ready_q;
	logic [31:0]            id_q;
	logic [3:0]             cnt_q;
	logic [2:0]             off_q;
	logic [HANDLE_BITS-1:0] hnd_q;

	logic [TRACKERS:0] hit_c, free_c;
	srt_match_t        mt [TRACKERS];
	logic [TRACKERS-1:0] alloc_v, rel_v;

	logic [TW-1:0] hidx_q, fidx_q;
	logic          hit_q, free_q;
	logic [3:0]    len_m [TRACKERS];
	logic [MAX_SEGMENTS-1:0] rcv_m [TRACKERS];
	logic [HANDLE_BITS-1:0]  store_m [TRACKERS*MAX_SEGMENTS];
	logic [HANDLE_BITS-1:0]  rd_q;
	logic [3:0]    len_q, idx_q;

	logic        st_we;
	logic [AW-1:0] st_wa, st_ra;
	logic        multi;

	assign hit_c[0]  = 1'b0;
	assign free_c[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < TRACKERS; g++) begin : g_row
			srt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.key_id   (id_q),
				.hit_in   (hit_c[g]),
				.free_in  (free_c[g]),
				.hit_out  (hit_c[g+1]),
				.free_out (free_c[g+1]),
				.match    (mt[g]),
				.alloc    (alloc_v[g]),
				.rel      (rel_v[g]),
				.alloc_id (id_q)
			);
		end
	endgenerate

	logic [TW-1:0] hsel, fsel;
	always_comb begin
		hsel = '0;
		fsel = '0;
		for (int i = 0; i < TRACKERS; i++) begin
			if (mt[i].hit)  hsel = TW'(i);
			if (mt[i].free) fsel = TW'(i);
		end
	end

	logic [3:0]              hlen;
	logic [MAX_SEGMENTS-1:0] hrcv, nrcv, fullm, obit;
	logic                    off_ok, new_ok, cnt_ok;
	assign hlen  = len_m[hidx_q];
	assign hrcv  = rcv_m[hidx_q];
	assign obit  = MAX_SEGMENTS'(1) << off_q;
	assign nrcv  = hrcv | obit;
	assign fullm = MAX_SEGMENTS'((33'd1 << hlen) - 33'd1);
	assign off_ok = {1'b0, off_q} < hlen;
	assign cnt_ok = (cnt_q != 4'd0) && (32'(cnt_q) <= 32'(MAX_SEGMENTS));
	assign new_ok = cnt_ok && ({1'b0, off_q} < cnt_q);

	// data segment of a multi-segment message goes through the tracker row
	assign multi = data_q && (cnt_q != 4'd1);

	logic [31:0] shifted;
	logic [3:0]  nib, sidx;
	logic        sok;
	assign shifted = id_q >> shift_q;
	assign nib     = shifted[3:0] & SENDER_NIBBLE;
	assign sidx    = nib - 4'd1;
	assign sok     = (nib != 4'd0) && (32'(sidx) < 32'(SENDERS));

	always_comb begin
		alloc_v = '0;
		rel_v   = '0;
		st_we   = 1'b0;
		st_wa   = {hidx_q, SW'(off_q)};
		if (state_q == ST_DEC && multi) begin
			if (hit_q && off_ok) begin
				st_we = 1'b1;
			end else if (!hit_q && new_ok && free_q) begin
				st_we = 1'b1;
				st_wa = {fidx_q, SW'(off_q)};
				alloc_v[fidx_q] = 1'b1;
			end
		end
		if (state_q == ST_EMIT && idx_q + 4'd1 == len_q) begin
			rel_v[hidx_q] = 1'b1;
		end
	end

	assign st_ra = {hidx_q, SW'(idx_q)};

	always_ff @(posedge clk) begin
		if (st_we) store_m[st_wa] <= hnd_q;
		rd_q <= store_m[st_ra];
		if (state_q == ST_DEC && multi) begin
			if (hit_q && off_ok) begin
				rcv_m[hidx_q] <= nrcv;
			end else if (!hit_q && new_ok && free_q) begin
				rcv_m[fidx_q] <= obit;
				len_m[fidx_q] <= cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 5'd24;
		end else if (cfg_we) begin
			shift_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
			idx_q   <= '0;
			len_q   <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					state_q <= ST_IDLE;
					if (multi && hit_q && off_ok && nrcv == fullm && ready_q) begin
						state_q <= ST_RD;
						idx_q   <= '0;
						len_q   <= hlen;
					end else begin
						strobe <= 1'b1;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe <= 1'b1;
					if (idx_q + 4'd1 == len_q) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			data_q  <= is_data;
			ack_q   <= ack_req;
			id_q    <= message_id;
			cnt_q   <= segment_count;
			off_q   <= segment_offset;
			hnd_q   <= buffer_handle;
			ready_q <= sink_ready;
		end
		if (state_q == ST_LOOK) begin
			hit_q  <= hit_c[TRACKERS];
			free_q <= free_c[TRACKERS];
			hidx_q <= hsel;
			fidx_q <= fsel;
		end
	end

	// result fields, registered alongside strobe
	always_ff @(posedge clk) begin
		accepted <= 1'b1; delivering <= 1'b0; out_buffer <= '0; out_segment <= '0;
		last <= 1'b1; ack_push <= 1'b0; ack_sender <= '0; ack_message_id <= '0;
		no_tracker <= 1'b0; bad_sender <= 1'b0;
		if (state_q == ST_DEC && data_q) begin
			if (cnt_q == 4'd1) begin
				if (!ready_q) begin
					accepted <= 1'b0;
				end else begin
					delivering <= 1'b1;
					out_buffer <= hnd_q;
					if (ack_q) begin
						ack_push       <= sok;
						bad_sender     <= !sok;
						ack_sender     <= sok ? sidx[1:0] : 2'd0;
						ack_message_id <= sok ? id_q : 32'd0;
					end
				end
			end else if (hit_q) begin
				if (off_ok && nrcv == fullm && !ready_q) accepted <= 1'b0;
			end else if (new_ok && !free_q) begin
				no_tracker <= 1'b1;
			end
		end
		if (state_q == ST_EMIT) begin
			delivering  <= 1'b1;
			out_buffer  <= rd_q;
			out_segment <= idx_q[2:0];
			last        <= (idx_q + 4'd1 == len_q);
			if (ack_q && idx_q + 4'd1 == len_q) begin
				ack_push       <= sok;
				bad_sender     <= !sok;
				ack_sender     <= sok ? sidx[1:0] : 2'd0;
				ack_message_id <= sok ? id_q : 32'd0;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> sim/segment_reassembly_tracker_test.sv
`timescale 1ns / 1ps

module segment_reassembly_tracker_test;
	import srt_pkg::*;

	localparam int TRACKERS     = 16;

	typedef struct packed {
		logic        is_data;
		logic        ack_req;
		logic [31:0] message_id;
		logic [3:0]  segment_count;
		logic [2:0]  segment_offset;
		logic [15:0] buffer_handle;
		logic        sink_ready;
	} segment_t;

	typedef struct packed {
		logic        accepted;
		logic        delivering;
		logic [15:0] out_buffer;
		logic [2:0]  out_segment;
		logic        last;
		logic        ack_push;
		logic [1:0]  ack_sender;
		logic [31:0] ack_message_id;
		logic        no_tracker;
		logic        bad_sender;
	} delivery_t;

	typedef struct {
		logic [31:0] id;
		logic [3:0]  count;
		logic [7:0]  missing;
		logic        ack;
		bit          opened;
	} message_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_we = 0;
	logic [4:0] cfg_wdata = '0;
	segment_t seg_drv = '0;
	logic strobe;
	delivery_t got;

	segment_t  pending_segs[$];
	delivery_t expected_q[$];
	message_t  open_msgs[$];

	// shadow of the block state
	logic [4:0]  sender_shift = 5'd24;
	logic        trk_valid[TRACKERS];
	logic [31:0] trk_id[TRACKERS];
	logic [3:0]  trk_len[TRACKERS];
	logic [7:0]  trk_rcv[TRACKERS];
	logic [15:0] seg_store[TRACKERS][MAX_SEGMENTS];

	int errors = 0;
	bit allow_gaps = 1;

	segment_reassembly_tracker u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.is_data(seg_drv.is_data), .ack_req(seg_drv.ack_req),
		.message_id(seg_drv.message_id), .segment_count(seg_drv.segment_count),
		.segment_offset(seg_drv.segment_offset), .buffer_handle(seg_drv.buffer_handle),
		.sink_ready(seg_drv.sink_ready),
		.strobe(strobe), .accepted(got.accepted), .delivering(got.delivering),
		.out_buffer(got.out_buffer), .out_segment(got.out_segment), .last(got.last),
		.ack_push(got.ack_push), .ack_sender(got.ack_sender),
		.ack_message_id(got.ack_message_id), .no_tracker(got.no_tracker),
		.bad_sender(got.bad_sender)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#500us;
		$display("FAILURE");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] g, input logic [31:0] e);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, g, e);
		errors++;
	endtask

	function automatic delivery_t with_ack(input delivery_t r, input logic [31:0] id);
		logic [3:0] nib;
		logic [3:0] idx;
		nib = 4'((id >> sender_shift) & SENDER_NIBBLE);
		idx = nib - 4'd1;
		if (nib != 0 && idx < SENDERS) begin
			r.ack_push = 1;
			r.ack_sender = idx[1:0];
			r.ack_message_id = id;
		end else begin
			r.bad_sender = 1;
		end
		return r;
	endfunction

	task automatic predict_delivery(input segment_t s);
		delivery_t r;
		int hit, fr;
		logic [3:0] len;
		logic [8:0] full;
		r = '0;
		r.accepted = 1;
		r.last = 1;
		hit = -1;
		fr = -1;
		if (!s.is_data) begin
			expected_q.insert(expected_q.size(), r);
			return;
		end
		if (s.segment_count == 1) begin
			if (!s.sink_ready) begin
				r.accepted = 0;
			end else begin
				r.delivering = 1;
				r.out_buffer = s.buffer_handle;
				if (s.ack_req) r = with_ack(r, s.message_id);
			end
			expected_q.insert(expected_q.size(), r);
			return;
		end
		for (int t = 0; t < TRACKERS; t++) begin
			if (trk_valid[t]) begin
				if (hit < 0 && trk_id[t] == s.message_id) hit = t;
			end else if (fr < 0) begin
				fr = t;
			end
		end
		if (hit >= 0) begin
			len = trk_len[hit];
			if (s.segment_offset >= len) begin
				expected_q.insert(expected_q.size(), r);
				return;
			end
			seg_store[hit][s.segment_offset] = s.buffer_handle;
			trk_rcv[hit][s.segment_offset] = 1'b1;
			full = (9'd1 << len) - 9'd1;
			if (trk_rcv[hit] != full[7:0]) begin
				expected_q.insert(expected_q.size(), r);
				return;
			end
			if (!s.sink_ready) begin
				r.accepted = 0;
				expected_q.insert(expected_q.size(), r);
				return;
			end
			for (int i = 0; i < len; i++) begin
				r = '0;
				r.accepted = 1;
				r.delivering = 1;
				r.out_buffer = seg_store[hit][i];
				r.out_segment = 3'(i);
				r.last = (i == len - 1);
				if (r.last && s.ack_req) r = with_ack(r, s.message_id);
				expected_q.insert(expected_q.size(), r);
			end
			trk_valid[hit] = 0;
			return;
		end
		if (s.segment_count == 0 || s.segment_count > MAX_SEGMENTS ||
		    s.segment_offset >= s.segment_count) begin
			expected_q.insert(expected_q.size(), r);
			return;
		end
		if (fr < 0) begin
			r.no_tracker = 1;
		end else begin
			trk_valid[fr] = 1;
			trk_id[fr] = s.message_id;
			trk_len[fr] = s.segment_count;
			trk_rcv[fr] = 8'd1 << s.segment_offset;
			seg_store[fr][s.segment_offset] = s.buffer_handle;
		end
		expected_q.insert(expected_q.size(), r);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) predict_delivery(seg_drv);
			if (!start || !busy) begin
				if (pending_segs.size() > 0 && !(allow_gaps && $urandom_range(99) < 21)) begin
					seg_drv <= pending_segs[0];
					pending_segs.delete(0);
					start <= 1;
				end else begin
					start <= 0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		delivery_t e;
		if (arst_n && strobe) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				e = expected_q[0];
				expected_q.delete(0);
				if (got.accepted !== e.accepted)
					report("accepted", 32'(got.accepted), 32'(e.accepted));
				if (got.delivering !== e.delivering)
					report("delivering", 32'(got.delivering), 32'(e.delivering));
				if (got.out_buffer !== e.out_buffer)
					report("out_buffer", 32'(got.out_buffer), 32'(e.out_buffer));
				if (got.out_segment !== e.out_segment)
					report("out_segment", 32'(got.out_segment), 32'(e.out_segment));
				if (got.last !== e.last) report("last", 32'(got.last), 32'(e.last));
				if (got.ack_push !== e.ack_push)
					report("ack_push", 32'(got.ack_push), 32'(e.ack_push));
				if (got.ack_sender !== e.ack_sender)
					report("ack_sender", 32'(got.ack_sender), 32'(e.ack_sender));
				if (got.ack_message_id !== e.ack_message_id)
					report("ack_message_id", got.ack_message_id, e.ack_message_id);
				if (got.no_tracker !== e.no_tracker)
					report("no_tracker", 32'(got.no_tracker), 32'(e.no_tracker));
				if (got.bad_sender !== e.bad_sender)
					report("bad_sender", 32'(got.bad_sender), 32'(e.bad_sender));
			end
		end
	end

	task automatic add_seg(input logic d, input logic a, input logic [31:0] id,
			input logic [3:0] cnt, input logic [2:0] off, input logic [15:0] h,
			input logic rdy);
		segment_t s;
		s.is_data = d;
		s.ack_req = a;
		s.message_id = id;
		s.segment_count = cnt;
		s.segment_offset = off;
		s.buffer_handle = h;
		s.sink_ready = rdy;
		pending_segs.insert(pending_segs.size(), s);
	endtask

	task automatic drain_and_settle();
		while (pending_segs.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_shift(input logic [4:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		sender_shift = v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// well-formed messages with shuffled segments, plus noise
	task automatic add_random(input int n);
		message_t m;
		int k, off;
		logic [3:0] cnt;
		repeat (n) begin
			if ($urandom_range(99) < 78) begin
				if (open_msgs.size() == 0 || (open_msgs.size() < 10 && $urandom_range(3) == 0)) begin
					m.id = $urandom;
					m.count = 4'($urandom_range(2, MAX_SEGMENTS));
					m.missing = 8'((9'd1 << m.count) - 9'd1);
					m.ack = 1'($urandom_range(1));
					m.opened = 0;
					open_msgs.insert(open_msgs.size(), m);
				end
				k = $urandom_range(open_msgs.size() - 1);
				m = open_msgs[k];
				do off = $urandom_range(m.count - 1); while (!m.missing[off]);
				cnt = m.count;
				if (m.opened && $urandom_range(2) == 0) cnt = 4'($urandom_range(2, 15));
				if (m.missing == (8'd1 << off)) begin
					if ($urandom_range(9) != 0) begin
						add_seg(1, m.ack, m.id, cnt, 3'(off), 16'($urandom), 1);
						open_msgs.delete(k);
					end else begin
						// refused completion, resent later
						add_seg(1, m.ack, m.id, cnt, 3'(off), 16'($urandom), 0);
					end
				end else begin
					add_seg(1, m.ack, m.id, cnt, 3'(off), 16'($urandom),
						1'($urandom_range(1)));
					m.missing[off] = 0;
					m.opened = 1;
					open_msgs[k] = m;
				end
			end else begin
				case ($urandom_range(3))
					0: add_seg(0, 1'($urandom_range(1)), $urandom, 4'($urandom),
						3'($urandom), 16'($urandom), 1'($urandom_range(1)));
					1: add_seg(1, 1'($urandom_range(1)), $urandom, 1, 3'($urandom),
						16'($urandom), $urandom_range(3) != 0);
					2: begin
						cnt = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
						add_seg(1, 1'($urandom_range(1)), $urandom, cnt, 3'($urandom),
							16'($urandom), 1);
					end
					default: begin
						cnt = 4'($urandom_range(2, 7));
						add_seg(1, 1'($urandom_range(1)), $urandom, cnt,
							3'($urandom_range(cnt, 7)), 16'($urandom), 1);
					end
				endcase
			end
		end
	endtask

	initial begin
		message_t m;
		for (int t = 0; t < TRACKERS; t++) trk_valid[t] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed, reset shift of 24
		add_seg(0, 1, 32'hffff_ffff, 4'hf, 3'd7, 16'hffff, 1);
		add_seg(1, 1, 32'h0123_4567, 1, 3'd5, 16'hffff, 1);
		add_seg(1, 1, 32'h0123_4567, 1, 3'd0, 16'h1234, 0);
		add_seg(1, 1, 32'h00ab_cdef, 1, 3'd0, 16'h0000, 1);
		add_seg(1, 1, 32'h06ab_cdef, 1, 3'd0, 16'h0001, 1);
		add_seg(1, 0, 32'h0400_0001, 4'd0, 3'd0, 16'h0002, 1);
		add_seg(1, 0, 32'h0400_0002, 4'd12, 3'd0, 16'h0003, 1);
		add_seg(1, 0, 32'h0400_0003, 4'd3, 3'd5, 16'h0004, 1);
		add_seg(1, 1, 32'h0400_00aa, 4'd2, 3'd1, 16'hffff, 1);
		add_seg(1, 1, 32'h0400_00aa, 4'd2, 3'd6, 16'h5555, 1);
		add_seg(1, 1, 32'h0400_00aa, 4'd9, 3'd0, 16'h0000, 0);
		add_seg(1, 1, 32'h0400_00aa, 4'd2, 3'd0, 16'h0000, 1);
		// fill every tracker, then one more new message is dropped
		for (int t = 0; t < TRACKERS; t++) begin
			m.id = 32'h0200_0000 + t;
			m.count = 4'd2;
			m.missing = 8'b10;
			m.ack = t[0];
			m.opened = 1;
			open_msgs.insert(open_msgs.size(), m);
			add_seg(1, m.ack, m.id, 4'd2, 3'd0, 16'($urandom), 1);
		end
		add_seg(1, 0, 32'h0300_0000, 4'd2, 3'd0, 16'h7777, 1);
		drain_and_settle();

		write_shift(5'd0);
		allow_gaps = 0;
		add_random(100);
		drain_and_settle();
		allow_gaps = 1;

		write_shift(5'd28);
		add_random(105);
		drain_and_settle();

		write_shift(5'd13);
		add_random(100);
		drain_and_settle();

		write_shift(5'd24);
		add_random(100);
		drain_and_settle();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/srt_pkg.sv
design/srt_cell.sv
design/segment_reassembly_tracker.sv
sim/segment_reassembly_tracker_test.sv
